@@ hdl/bblim_pkg.sv @@
// shared types, constants and helper functions for the battery level brightness limiter
package bblim_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int ADC_FIELD_W = 12;
    localparam int REF_W      = 13;
    localparam int FS_W       = 12;
    localparam int DIV_W      = 16;
    localparam int MV_W       = 16;
    localparam int LEVEL_W    = 3;
    localparam int LIMIT_W    = 8;
    localparam int TICK_W     = 8;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // conversion arithmetic: the two divisions by den and by ten fold into one
    localparam int SCALE_UP = 10000;
    localparam int MV_SCALE = SCALE_UP / 10;
    localparam int SCALE_W  = 10;
    localparam int PROD_W   = ADC_FIELD_W + REF_W;
    localparam int NUM_W    = PROD_W + SCALE_W;
    localparam int DEN_W    = FS_W + DIV_W;
    localparam int SAT_W    = DEN_W + MV_W;
    localparam int DSH_W    = DEN_W + MV_W - 1;
    localparam int STEP_W   = $clog2(MV_W);

    localparam logic [MV_W-1:0] MV_MAX    = '1;
    localparam logic [MV_W-1:0] HIGH_MV   = 16'd3800;
    localparam logic [MV_W-1:0] MEDIUM_MV = 16'd3500;

    // battery levels
    localparam logic [LEVEL_W-1:0] LVL_FULL    = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_HIGH    = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_MEDIUM  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_LOW     = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_PROTECT = 3'd4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd255;

    // register map
    localparam int ADDR_W = 5;
    localparam int REGIDX_W = 3;
    localparam logic [REGIDX_W-1:0] REG_REFERENCE = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_FULLSCALE = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_DIVIDER   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_FULL      = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_PROTECT   = 3'd4;
    localparam logic [REGIDX_W-1:0] REG_RECOVER   = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [ADC_FIELD_W-1:0] code;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qport;

    typedef struct packed {
        logic [REF_W-1:0] reference_mv;
        logic [FS_W-1:0]  adc_full_scale;
        logic [DIV_W-1:0] divider_milli;
        logic [MV_W-1:0]  full_mv;
        logic [MV_W-1:0]  protect_mv;
        logic [MV_W-1:0]  recover_mv;
    } t_cfg;

    typedef struct packed {
        logic                   start;
        logic [ADC_FIELD_W-1:0] code;
    } t_conv_req;

    typedef struct packed {
        logic            done;
        logic [MV_W-1:0] mv;
    } t_conv_res;

    typedef struct packed {
        logic [MV_W-1:0]    battery_mv;
        logic [LEVEL_W-1:0] battery_level;
        logic [LIMIT_W-1:0] target_limit;
        logic [LIMIT_W-1:0] current_limit;
        logic               protect_active;
    } t_result;

    function automatic logic [LEVEL_W-1:0] grade(
        input logic [MV_W-1:0] mv,
        input logic [MV_W-1:0] full_mv,
        input logic [MV_W-1:0] protect_mv
    );
        logic [LEVEL_W-1:0] lvl;
        if (mv >= full_mv) begin
            lvl = LVL_FULL;
        end else if (mv >= HIGH_MV) begin
            lvl = LVL_HIGH;
        end else if (mv >= MEDIUM_MV) begin
            lvl = LVL_MEDIUM;
        end else if (mv >= protect_mv) begin
            lvl = LVL_LOW;
        end else begin
            lvl = LVL_PROTECT;
        end
        return lvl;
    endfunction

    function automatic logic [LIMIT_W-1:0] level_limit(input logic [LEVEL_W-1:0] lvl);
        logic [LIMIT_W-1:0] lim;
        unique case (lvl)
            LVL_FULL:   lim = 8'd255;
            LVL_HIGH:   lim = 8'd220;
            LVL_MEDIUM: lim = 8'd180;
            LVL_LOW:    lim = 8'd140;
            default:    lim = 8'd100;
        endcase
        return lim;
    endfunction

endpackage

@@ hdl/bblim_front.sv @@
// front end: takes requests from the input stream, classifies them and queues them
module bblim_front #(
    parameter int ADC_BITS = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [bblim_pkg::OP_W-1:0]       i_op,
    input  logic [bblim_pkg::ADC_FIELD_W-1:0] i_code,
    input  logic                             i_pop,
    output bblim_pkg::t_qport                o_q
);
    import bblim_pkg::*;

    localparam int CODE_BITS = (ADC_BITS < ADC_FIELD_W) ? ADC_BITS : ADC_FIELD_W;
    localparam logic [ADC_FIELD_W-1:0] CODE_MASK = ADC_FIELD_W'((33'd1 << CODE_BITS) - 33'd1);

    t_item              r_qmem [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QPTR_W:0]    r_cnt;
    t_item              w_item;
    logic               w_push;
    logic               w_pop;

    // classify: only a sample carries a code, the rest travel with a clean payload
    always_comb begin
        w_item.op   = OP_NONE;
        w_item.code = '0;
        unique case (i_op)
            OP_SAMPLE: begin
                w_item.op   = OP_SAMPLE;
                w_item.code = i_code & CODE_MASK;
            end
            OP_TICK:  w_item.op = OP_TICK;
            OP_CLEAR: w_item.op = OP_CLEAR;
            default:  w_item.op = OP_NONE;
        endcase
    end

    assign o_ready = (r_cnt != (QPTR_W+1)'(QDEPTH));
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_qmem[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(w_push) - (QPTR_W+1)'(w_pop);
        end
    end

    assign o_q.valid = (r_cnt != '0);
    assign o_q.item  = r_qmem[r_rp];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("request queue overfilled");

endmodule

@@ hdl/bblim_conv.sv @@
// conversion unit: adc code to millivolts by three products and a restoring divider
module bblim_conv (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bblim_pkg::t_cfg       i_cfg,
    input  bblim_pkg::t_conv_req  i_req,
    output bblim_pkg::t_conv_res  o_res
);
    import bblim_pkg::*;

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_MUL   = 4'b0010,
        C_CHECK = 4'b0100,
        C_DIV   = 4'b1000
    } t_cstate;

    t_cstate            r_state;
    logic [PROD_W-1:0]  r_prod;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]   r_rem;
    logic [DSH_W-1:0]   r_dsh;
    logic [MV_W-1:0]    r_q;
    logic [STEP_W-1:0]  r_step;
    logic [MV_W-1:0]    r_mv;
    logic               r_done;
    logic               w_sat;
    logic               w_ge;

    // saturate on a zero den, or when the quotient is above 16 bits: num >= den * 2^16
    assign w_sat = (r_den == '0) || (SAT_W'(r_num) >= {r_den, MV_W'(0)});
    assign w_ge  = (DSH_W'(r_rem) >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_req.start) begin
                        r_state <= C_MUL;
                    end
                end
                C_MUL:   r_state <= C_CHECK;
                C_CHECK: begin
                    if (w_sat) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= C_DIV;
                    end
                end
                C_DIV: begin
                    if (r_step == '0) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            C_IDLE: begin
                r_prod <= PROD_W'(i_req.code) * PROD_W'(i_cfg.reference_mv);
                r_den  <= DEN_W'(i_cfg.adc_full_scale) * DEN_W'(i_cfg.divider_milli);
            end
            C_MUL: begin
                r_num <= NUM_W'(r_prod) * NUM_W'(MV_SCALE);
            end
            C_CHECK: begin
                r_rem  <= r_num;
                r_dsh  <= {r_den, (MV_W-1)'(0)};
                r_q    <= '0;
                r_step <= STEP_W'(MV_W-1);
                if (w_sat) begin
                    r_mv <= MV_MAX;
                end
            end
            C_DIV: begin
                if (w_ge) begin
                    r_rem <= r_rem - r_dsh[NUM_W-1:0];
                end
                r_dsh  <= r_dsh >> 1;
                r_q    <= {r_q[MV_W-2:0], w_ge};
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_mv <= {r_q[MV_W-2:0], w_ge};
                end
            end
            default: ;
        endcase
    end

    assign o_res.done = r_done;
    assign o_res.mv   = r_mv;

    // restoring step invariant: remainder stays below twice the shifted divisor
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_DIV) |-> (SAT_W'(r_rem) < SAT_W'({r_dsh, 1'b0})))
        else $error("divider remainder out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> (r_state == C_IDLE))
        else $error("conversion started while busy");

endmodule

@@ hdl/bblim_back.sv @@
// back end: executes queued requests, holds the limiter state and the result register
module bblim_back #(
    parameter int FADE_PERIOD = 250
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bblim_pkg::t_cfg       i_cfg,
    input  bblim_pkg::t_qport     i_q,
    output logic                  o_pop,
    output bblim_pkg::t_conv_req  o_conv_req,
    input  bblim_pkg::t_conv_res  i_conv_res,
    output logic                  o_valid,
    input  logic                  i_ready,
    output bblim_pkg::t_result    o_result
);
    import bblim_pkg::*;

    localparam logic [TICK_W-1:0] FADE_LAST = TICK_W'(FADE_PERIOD);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_CONV  = 3'b010,
        B_APPLY = 3'b100
    } t_bstate;

    t_bstate             r_state;
    t_op                 r_op;
    logic [MV_W-1:0]     r_mv;
    logic [LEVEL_W-1:0]  r_level;
    logic [LIMIT_W-1:0]  r_target;
    logic [LIMIT_W-1:0]  r_ramp;
    logic [TICK_W-1:0]   r_tick;
    logic                r_flag;
    logic                r_out_valid;
    t_result             r_out;

    logic [MV_W-1:0]     n_mv;
    logic [LEVEL_W-1:0]  n_level;
    logic [LIMIT_W-1:0]  n_target;
    logic [LIMIT_W-1:0]  n_ramp;
    logic [TICK_W-1:0]   n_tick;
    logic                n_flag;
    logic [TICK_W-1:0]   w_tick_inc;
    logic                w_slot;
    logic                w_commit;

    assign o_pop            = (r_state == B_IDLE) && i_q.valid;
    assign o_conv_req.start = o_pop && (i_q.item.op == OP_SAMPLE);
    assign o_conv_req.code  = i_q.item.code;

    // result slot free when empty or being taken this cycle
    assign w_slot   = !r_out_valid || i_ready;
    assign w_commit = (r_state == B_APPLY) && w_slot;

    assign w_tick_inc = r_tick + 1'b1;

    always_comb begin
        n_mv     = r_mv;
        n_level  = r_level;
        n_target = r_target;
        n_ramp   = r_ramp;
        n_tick   = r_tick;
        n_flag   = r_flag;
        unique case (r_op)
            OP_SAMPLE: begin
                n_mv     = i_conv_res.mv;
                n_level  = grade(i_conv_res.mv, i_cfg.full_mv, i_cfg.protect_mv);
                n_target = level_limit(n_level);
                // hysteresis between trip and release thresholds
                if ((i_conv_res.mv < i_cfg.protect_mv) && !r_flag) begin
                    n_flag = 1'b1;
                end else if ((i_conv_res.mv > i_cfg.recover_mv) && r_flag) begin
                    n_flag = 1'b0;
                end
            end
            OP_TICK: begin
                if (r_ramp != r_target) begin
                    if (w_tick_inc >= FADE_LAST) begin
                        n_tick = '0;
                        if (r_target > r_ramp) begin
                            n_ramp = r_ramp + 1'b1;
                        end else begin
                            n_ramp = r_ramp - 1'b1;
                        end
                    end else begin
                        n_tick = w_tick_inc;
                    end
                end
            end
            OP_CLEAR: n_flag = 1'b0;
            OP_NONE:  ;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_op        <= OP_NONE;
            r_mv        <= '0;
            r_level     <= LVL_FULL;
            r_target    <= LIMIT_RESET;
            r_ramp      <= LIMIT_RESET;
            r_tick      <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (i_q.valid) begin
                        r_op <= i_q.item.op;
                        if (i_q.item.op == OP_SAMPLE) begin
                            r_state <= B_CONV;
                        end else begin
                            r_state <= B_APPLY;
                        end
                    end
                end
                B_CONV: begin
                    if (i_conv_res.done) begin
                        r_state <= B_APPLY;
                    end
                end
                B_APPLY: begin
                    if (w_slot) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase

            if (w_commit) begin
                r_mv     <= n_mv;
                r_level  <= n_level;
                r_target <= n_target;
                r_ramp   <= n_ramp;
                r_tick   <= n_tick;
                r_flag   <= n_flag;
            end

            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out.battery_mv     <= n_mv;
            r_out.battery_level  <= n_level;
            r_out.target_limit   <= n_target;
            r_out.current_limit  <= n_ramp;
            r_out.protect_active <= n_flag;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_conv_res.done |-> (r_state == B_CONV))
        else $error("conversion finished with no sample waiting");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick < FADE_LAST)
        else $error("fade counter passed its period");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_ramp != $past(r_ramp))) |->
            ((r_ramp == $past(r_ramp) + 8'd1) || (r_ramp == $past(r_ramp) - 8'd1)))
        else $error("ramped limit moved by more than one step");

endmodule

@@ hdl/battery_level_brightness_limiter.sv @@
// top level of the battery level brightness limiter: register file, front, back, converter
// sample path: a taken sample request passes two product stages, a saturation check and 16
//   divider steps, the divider steps skipped when it saturates; other requests skip the converter
// flow: the back end takes a new request only once the last one is committed to the result register;
//   a 4-deep queue and a one-entry result register let input and output stall independently
// reset: synchronous, active low; settings to 2400/1023/500/4200/3300/3600, limits to 255,
//   level full, voltage 0, protection off; no clearing pass, ready right out of reset
module battery_level_brightness_limiter #(
    parameter int ADC_BITS    = 12,
    parameter int FADE_PERIOD = 250
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation

    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [15:0] battery_mv, [18:16] battery_level,
                                        // [26:19] target_limit, [34:27] current_limit,
                                        // [35] protect_active, [39:36] zero

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bblim_pkg::*;

    // register file
    logic [REF_W-1:0]    r_reference_mv;
    logic [FS_W-1:0]     r_adc_full_scale;
    logic [DIV_W-1:0]    r_divider_milli;
    logic [MV_W-1:0]     r_full_mv;
    logic [MV_W-1:0]     r_protect_mv;
    logic [MV_W-1:0]     r_recover_mv;

    logic [REGIDX_W-1:0] w_idx;
    logic                w_wr;
    t_cfg                w_cfg;
    t_qport              w_q;
    logic                w_pop;
    t_conv_req           w_conv_req;
    t_conv_res           w_conv_res;
    t_result             w_result;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes land on the access phase; unmapped slots are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reference_mv   <= 13'd2400;
            r_adc_full_scale <= 12'd1023;
            r_divider_milli  <= 16'd500;
            r_full_mv        <= 16'd4200;
            r_protect_mv     <= 16'd3300;
            r_recover_mv     <= 16'd3600;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_REFERENCE: r_reference_mv   <= pwdata[REF_W-1:0];
                REG_FULLSCALE: r_adc_full_scale <= pwdata[FS_W-1:0];
                REG_DIVIDER:   r_divider_milli  <= pwdata[DIV_W-1:0];
                REG_FULL:      r_full_mv        <= pwdata[MV_W-1:0];
                REG_PROTECT:   r_protect_mv     <= pwdata[MV_W-1:0];
                REG_RECOVER:   r_recover_mv     <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // read back, zero for unmapped slots
    always_comb begin
        unique case (w_idx)
            REG_REFERENCE: prdata = 32'(r_reference_mv);
            REG_FULLSCALE: prdata = 32'(r_adc_full_scale);
            REG_DIVIDER:   prdata = 32'(r_divider_milli);
            REG_FULL:      prdata = 32'(r_full_mv);
            REG_PROTECT:   prdata = 32'(r_protect_mv);
            REG_RECOVER:   prdata = 32'(r_recover_mv);
            default:       prdata = '0;
        endcase
    end

    assign w_cfg.reference_mv   = r_reference_mv;
    assign w_cfg.adc_full_scale = r_adc_full_scale;
    assign w_cfg.divider_milli  = r_divider_milli;
    assign w_cfg.full_mv        = r_full_mv;
    assign w_cfg.protect_mv     = r_protect_mv;
    assign w_cfg.recover_mv     = r_recover_mv;

    // front: accept, classify and queue requests
    bblim_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (s_axis_tuser),
        .i_code  (s_axis_tdata[ADC_FIELD_W-1:0]),
        .i_pop   (w_pop),
        .o_q     (w_q)
    );

    // shared converter used by sample requests
    bblim_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_req   (w_conv_req),
        .o_res   (w_conv_res)
    );

    // back: sequence requests, update limiter state, hold the result
    bblim_back #(
        .FADE_PERIOD (FADE_PERIOD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_q        (w_q),
        .o_pop      (w_pop),
        .o_conv_req (w_conv_req),
        .i_conv_res (w_conv_res),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    // result packing, first field in the low bits
    assign m_axis_tdata = {4'b0000,
                           w_result.protect_active,
                           w_result.current_limit,
                           w_result.target_limit,
                           w_result.battery_level,
                           w_result.battery_mv};

endmodule

@@ test/battery_level_brightness_limiter_tb.sv @@
// self-checking testbench for the battery level brightness limiter: streams requests, predicts every result
module battery_level_brightness_limiter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bblim_pkg::*;

    localparam int ADC_BITS_TB    = 12;
    localparam int FADE_TICKS     = 250;
    localparam int WATCHDOG_LIMIT = 3000;  // idle cycles allowed before giving up
    localparam int PRINT_LIMIT    = 40;    // cap on mismatch lines
    localparam int TAIL_CYCLES    = 30;    // settle time after the last result

    // brightness limit per battery level, full down to protected
    localparam logic [LIMIT_W-1:0] LEVEL_LIMITS [5] = '{8'd255, 8'd220, 8'd180, 8'd140, 8'd100};

    // clock, reset and block ports, the driven ones known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [11:0] adc_sample, [15:12] zero
    logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // [15:0] battery_mv, [18:16] battery_level,
                                      // [26:19] target_limit, [34:27] current_limit,
                                      // [35] protect_active, [39:36] zero
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the register file, reset values
    logic [REF_W-1:0] cfg_reference  = 13'd2400;
    logic [FS_W-1:0]  cfg_full_scale = 12'd1023;
    logic [DIV_W-1:0] cfg_divider    = 16'd500;
    logic [MV_W-1:0]  cfg_full       = 16'd4200;
    logic [MV_W-1:0]  cfg_protect    = 16'd3300;
    logic [MV_W-1:0]  cfg_recover    = 16'd3600;

    // predictor copy of the limiter state, reset values
    logic [MV_W-1:0]    pred_mv      = '0;
    logic [LEVEL_W-1:0] pred_level   = LVL_FULL;
    logic [LIMIT_W-1:0] pred_target  = LIMIT_RESET;
    logic [LIMIT_W-1:0] pred_ramp    = LIMIT_RESET;
    logic [TICK_W-1:0]  pred_ticks   = '0;
    logic               pred_protect = 1'b0;

    t_result expected_results [$];
    int unsigned mismatches = 0;
    int unsigned idle_cycles = 0;

    // traffic shaping, switched by the test tasks
    bit tx_bursty = 1'b0;
    bit rx_stalls = 1'b0;
    int unsigned burst_left = 0;
    int unsigned rx_hold = 0;

    always #4 i_clk = ~i_clk;

    battery_level_brightness_limiter #(
        .ADC_BITS    (ADC_BITS_TB),
        .FADE_PERIOD (FADE_TICKS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // code -> millivolts, wide product, both divisions truncating, saturated
    function automatic logic [MV_W-1:0] convert_to_mv(input logic [ADC_FIELD_W-1:0] code);
        logic [63:0] numerator;
        logic [63:0] denominator;
        logic [63:0] quotient;
        denominator = 64'(cfg_full_scale) * 64'(cfg_divider);
        if (denominator == 64'd0) begin
            return MV_MAX;   // zero denominator saturates
        end
        numerator = 64'(code) * 64'(cfg_reference) * 64'(SCALE_UP);
        quotient  = (numerator / denominator) / 64'd10;
        return (quotient > 64'(MV_MAX)) ? MV_MAX : quotient[MV_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] level_of(input logic [MV_W-1:0] mv);
        if (mv >= cfg_full) begin
            return LVL_FULL;
        end else if (mv >= HIGH_MV) begin
            return LVL_HIGH;
        end else if (mv >= MEDIUM_MV) begin
            return LVL_MEDIUM;
        end else if (mv >= cfg_protect) begin
            return LVL_LOW;
        end
        return LVL_PROTECT;
    endfunction

    // advance the limiter state by one request and report the state after it
    function automatic t_result predict_item(input t_op op, input logic [ADC_FIELD_W-1:0] code);
        t_result res;
        case (op)
            OP_SAMPLE: begin
                pred_mv     = convert_to_mv(code);
                pred_level  = level_of(pred_mv);
                pred_target = LEVEL_LIMITS[pred_level];
                // hysteresis: trip below protect, release only above recover
                if (pred_mv < cfg_protect && !pred_protect) begin
                    pred_protect = 1'b1;
                end else if (pred_mv > cfg_recover && pred_protect) begin
                    pred_protect = 1'b0;
                end
            end
            OP_TICK: begin
                // the tick counter only runs while the ramp is off target
                if (pred_ramp != pred_target) begin
                    pred_ticks = pred_ticks + 1'b1;
                    if (pred_ticks >= FADE_TICKS) begin
                        pred_ticks = '0;
                        if (pred_target > pred_ramp) begin
                            pred_ramp = pred_ramp + 1'b1;
                        end else begin
                            pred_ramp = pred_ramp - 1'b1;
                        end
                    end
                end
            end
            OP_CLEAR: begin
                pred_protect = 1'b0;
            end
            default: begin
                // unknown operation leaves everything as it is
            end
        endcase
        res.battery_mv     = pred_mv;
        res.battery_level  = pred_level;
        res.target_limit   = pred_target;
        res.current_limit  = pred_ramp;
        res.protect_active = pred_protect;
        return res;
    endfunction

    // a code whose voltage lands within a few steps of the given millivolts
    function automatic logic [ADC_FIELD_W-1:0] code_near(input logic [MV_W-1:0] mv_target);
        logic [63:0] denominator;
        logic [63:0] base;
        int          guess;
        denominator = 64'(cfg_full_scale) * 64'(cfg_divider);
        if (denominator == 64'd0 || cfg_reference == '0) begin
            return ADC_FIELD_W'($urandom_range(0, 4095));
        end
        base = (64'(mv_target) * 64'd10 * denominator) / (64'(cfg_reference) * 64'(SCALE_UP));
        if (base > 64'd4095) begin
            base = 64'd4095;
        end
        guess = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (guess < 0) begin
            guess = 0;
        end else if (guess > 4095) begin
            guess = 4095;
        end
        return ADC_FIELD_W'(guess);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    // every result taken is compared with the oldest waiting prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT) begin
                    $display("%0t unexpected result: expected none actual %h", $time,
                             m_axis_tdata);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("battery_mv", want.battery_mv, m_axis_tdata[15:0]);
                check_field("battery_level", want.battery_level, m_axis_tdata[18:16]);
                check_field("target_limit", want.target_limit, m_axis_tdata[26:19]);
                check_field("current_limit", want.current_limit, m_axis_tdata[34:27]);
                check_field("protect_active", want.protect_active, m_axis_tdata[35]);
                check_field("result padding", 0, m_axis_tdata[39:36]);
            end
        end
    end

    // result side back-pressure: holds ready or stall for random stretches
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_hold       <= rx_stalls ? $urandom_range(1, 16) : 1;
            m_axis_tready <= rx_stalls ? ($urandom_range(0, 2) != 0) : 1'b1;
        end else begin
            rx_hold <= rx_hold - 1;
        end
    end

    // watchdog: any handshake or register access counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles", $time, idle_cycles);
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one request; valid stays high across a burst, dropped only for a gap
    task automatic send_request(input t_op op, input logic [ADC_FIELD_W-1:0] code);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = tx_bursty ? $urandom_range(1, 12) : 64;
            gap        = tx_bursty ? $urandom_range(0, 10) : 0;
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0000, code};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_results.push_back(predict_item(op, code));
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write (setup then access), then read back through the same port
    task automatic write_register(input logic [REGIDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            REG_REFERENCE: stored = value & 32'h1FFF;
            REG_FULLSCALE: stored = value & 32'h0FFF;
            default:       stored = value & 32'hFFFF;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_REFERENCE: cfg_reference  = stored[REF_W-1:0];
            REG_FULLSCALE: cfg_full_scale = stored[FS_W-1:0];
            REG_DIVIDER:   cfg_divider    = stored[DIV_W-1:0];
            REG_FULL:      cfg_full       = stored[MV_W-1:0];
            REG_PROTECT:   cfg_protect    = stored[MV_W-1:0];
            default:       cfg_recover    = stored[MV_W-1:0];
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("register readback", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure_all(input logic [31:0] reference, input logic [31:0] full_scale,
                                 input logic [31:0] divider, input logic [31:0] full,
                                 input logic [31:0] protect, input logic [31:0] recover);
        write_register(REG_REFERENCE, reference);
        write_register(REG_FULLSCALE, full_scale);
        write_register(REG_DIVIDER, divider);
        write_register(REG_FULL, full);
        write_register(REG_PROTECT, protect);
        write_register(REG_RECOVER, recover);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, every operation and the protection hysteresis at reset settings
    task automatic test_operations_and_hysteresis();
        tx_bursty = 1'b0;
        rx_stalls = 1'b0;
        send_request(OP_TICK, 12'd0);          // ramp on target: counter holds
        send_request(OP_NONE, 12'hFFF);        // unknown operation reports state
        send_request(OP_CLEAR, 12'hFFF);
        send_request(OP_SAMPLE, 12'd0);        // zero volts, protection trips
        send_request(OP_TICK, 12'd0);          // ramp now off target
        send_request(OP_SAMPLE, 12'hFFF);      // full scale code, protection releases
        send_request(OP_SAMPLE, 12'd0);
        send_request(OP_CLEAR, 12'd0);         // forced release while still low
        send_request(OP_SAMPLE, code_near(16'd3000));
        send_request(OP_SAMPLE, code_near(16'd3450));   // between the two thresholds: holds
        send_request(OP_SAMPLE, code_near(16'd3800));
        send_request(OP_SAMPLE, code_near(16'd4200));
        send_request(OP_SAMPLE, code_near(16'd3520));
        send_request(OP_NONE, 12'd0);
        drain_results();
    endtask

    // register extremes, zero denominators and a zero reference
    task automatic test_register_extremes();
        rx_stalls = 1'b1;
        configure_all(32'h1FFF, 32'd1, 32'd1, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        send_request(OP_SAMPLE, 12'd1);        // far above range: saturates
        send_request(OP_SAMPLE, 12'hFFF);
        drain_results();
        configure_all(32'd1, 32'd4095, 32'd65535, 32'hFFFF, 32'hFFFF, 32'hFFFF);
        send_request(OP_SAMPLE, 12'hFFF);      // rounds down to zero volts
        drain_results();
        configure_all(32'd5000, 32'd4095, 32'd65535, 32'd0, 32'd0, 32'd0);
        send_request(OP_SAMPLE, 12'hFFF);      // zero thresholds: full, and a set flag releases
        send_request(OP_CLEAR, 12'd0);
        drain_results();
        write_register(REG_FULLSCALE, 32'd0);  // zero full scale
        send_request(OP_SAMPLE, 12'd5);
        drain_results();
        write_register(REG_FULLSCALE, 32'd1023);
        write_register(REG_DIVIDER, 32'd0);    // zero divider
        send_request(OP_SAMPLE, 12'd5);
        drain_results();
        write_register(REG_DIVIDER, 32'd500);
        write_register(REG_REFERENCE, 32'd0);  // zero reference reads as zero volts
        send_request(OP_SAMPLE, 12'hABC);
        drain_results();
        configure_all(32'd2400, 32'd1023, 32'd500, 32'd4200, 32'd3300, 32'd3600);
    endtask

    // long tick runs: one step down, then back up to a higher target and hold there
    task automatic test_fade_ramp();
        tx_bursty = 1'b1;
        rx_stalls = 1'b1;
        send_request(OP_SAMPLE, code_near(16'd3000));
        repeat (FADE_TICKS + 10) send_request(OP_TICK, ADC_FIELD_W'($urandom));
        send_request(OP_SAMPLE, 12'hFFF);
        repeat (FADE_TICKS + 10) send_request(OP_TICK, ADC_FIELD_W'($urandom));
        drain_results();
    endtask

    // mixed traffic over several register settings, codes mostly near thresholds
    task automatic test_random_traffic();
        int unsigned pick;
        logic [MV_W-1:0] near_mv;
        logic [MV_W-1:0] protect_mv;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase != 0) begin
                protect_mv = MV_W'($urandom_range(2800, 3500));
                configure_all($urandom_range(1000, 5000),
                              ($urandom_range(0, 1) != 0) ? 1023 : $urandom_range(255, 4095),
                              $urandom_range(200, 2000), $urandom_range(3900, 4600),
                              protect_mv, protect_mv + $urandom_range(0, 500) - 50);
            end
            // first phase runs without any idling on either side
            tx_bursty = (phase != 0);
            rx_stalls = (phase != 0);
            repeat (90) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    case ($urandom_range(0, 4))
                        0: near_mv = cfg_full;
                        1: near_mv = HIGH_MV;
                        2: near_mv = MEDIUM_MV;
                        3: near_mv = cfg_protect;
                        default: near_mv = cfg_recover;
                    endcase
                    if ($urandom_range(0, 9) < 7) begin
                        send_request(OP_SAMPLE, code_near(near_mv));
                    end else begin
                        send_request(OP_SAMPLE, ADC_FIELD_W'($urandom));
                    end
                end else if (pick < 85) begin
                    send_request(OP_TICK, ADC_FIELD_W'($urandom));
                end else if (pick < 95) begin
                    send_request(OP_CLEAR, ADC_FIELD_W'($urandom));
                end else begin
                    send_request(OP_NONE, ADC_FIELD_W'($urandom));
                end
            end
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operations_and_hysteresis();
        test_register_extremes();
        test_fade_ramp();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            mismatches++;
            $display("%0t missing results: expected %0d more actual 0", $time,
                     expected_results.size());
        end
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/bblim_pkg.sv
hdl/bblim_front.sv
hdl/bblim_conv.sv
hdl/bblim_back.sv
hdl/battery_level_brightness_limiter.sv
test/battery_level_brightness_limiter_tb.sv
